// ===== design/lzwe_pkg.sv =====
// Shared constants, state type and hash helpers for the LZW encoder.
`default_nettype none
package lzwe_pkg;

    localparam int HASH_BUCKETS_DEF    = 16384;
    localparam int CAM_ENTRIES_DEF     = 64;
    localparam int MAX_CHUNK_BYTES_DEF = 8192;

    localparam int KEY_W   = 21;
    localparam int CODE_W  = 13;
    localparam int COUNT_W = 14;
    localparam int WAY_W   = 35;
    localparam int SLICE_W = 9;
    localparam int SLICE_DEPTH = 512;

    localparam logic [31:0] HASH_SEED = 32'd524057;
    localparam logic [31:0] MUR_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2    = 32'h1b873593;
    localparam logic [31:0] MUR_ADD   = 32'he6546b64;
    localparam logic [31:0] MUR_F1    = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2    = 32'hc2b2ae35;
    localparam logic [31:0] MUR_MUL5  = 32'd5;

    localparam logic [COUNT_W-1:0] FIRST_CODE = 14'd256;
    localparam logic [COUNT_W-1:0] CODE_LIMIT = 14'd8192;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_H4,
        ST_H5,
        ST_RD,
        ST_CMP,
        ST_CAMV,
        ST_EMIT,
        ST_FLUSH
    } lzwe_state_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        rotl15 = {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        rotl13 = {v[18:0], v[31:19]};
    endfunction

endpackage
`default_nettype wire

// ===== design/lzwe_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/lzw_encoder_hash_cam_dict.sv =====
// LZW encoder: byte stream in, 13-bit codes out, hashed two-way dictionary plus CAM.
// A byte is taken only in the idle state, so a new byte waits until the last one has been looked up,
// emitted or flushed; the lookup runs through five registered hash multiplies and the registered
// memory reads, and an emit or flush waits while an output beat is held. A first byte,
// and reset (aresetn low, synchronous), run a clearing pass over every hash bucket and bitmap row.
`default_nettype none
module lzw_encoder_hash_cam_dict
    import lzwe_pkg::*;
#(
    parameter int HASH_BUCKETS    = HASH_BUCKETS_DEF,
    parameter int CAM_ENTRIES     = CAM_ENTRIES_DEF,
    parameter int MAX_CHUNK_BYTES = MAX_CHUNK_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // first_of_chunk
    input  wire logic        s_tlast,   // last_of_chunk
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [12:0] out_code, [26:13] code_count, [27] dict_failure
    output logic             m_tlast    // chunk_end
);
    localparam int HB_W  = $clog2(HASH_BUCKETS);
    localparam int CLR_N = (HASH_BUCKETS > SLICE_DEPTH) ? HASH_BUCKETS : SLICE_DEPTH;
    localparam int CLR_W = $clog2(CLR_N);
    localparam int FILL_W = $clog2(CAM_ENTRIES + 1);
    localparam int IDX_W  = $clog2(CAM_ENTRIES);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
    localparam logic [FILL_W-1:0] CAM_FULL = FILL_W'(CAM_ENTRIES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CHUNK_BYTES);

    lzwe_state_t state_reg, state_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [31:0]        h_reg, h_next;
    logic [31:0]        s_reg, s_next;
    logic [CODE_W-1:0]  prefix_reg, prefix_next;
    logic [COUNT_W-1:0] free_code_reg, free_code_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               fail_reg, fail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic               last_reg, last_next;
    logic               m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]  m_code_reg, m_code_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic               m_fail_reg, m_fail_next;
    logic               m_last_reg, m_last_next;

    // Memory ports
    logic                     hash_we;
    logic [HB_W-1:0]          hash_waddr, hash_raddr;
    logic [2*WAY_W-1:0]       hash_wdata, hash_rdata;
    logic                     bm_we;
    logic [SLICE_W-1:0]       bm_waddr [3];
    logic [SLICE_W-1:0]       bm_raddr [3];
    logic [CAM_ENTRIES-1:0]   bm_wdata [3];
    logic [CAM_ENTRIES-1:0]   bm_rdata [3];
    logic                     cv_we;
    logic [IDX_W-1:0]         cv_raddr;
    logic [CODE_W-1:0]        cv_rdata;

    logic [31:0]            h_fin;
    logic [WAY_W-1:0]       way0, way1, new_entry;
    logic                   way0_hit, way1_hit;
    logic [CAM_ENTRIES-1:0] match, new_bit;
    logic [IDX_W-1:0]       match_idx;
    logic                   out_free;
    logic [31:0]            mix_a, mix_b;
    logic [COUNT_W-1:0]     count_inc;

    lzwe_ram #(.WIDTH(2*WAY_W), .DEPTH(HASH_BUCKETS)) u_hash_ram (
        .aclk(aclk), .we(hash_we), .waddr(hash_waddr), .wdata(hash_wdata),
        .raddr(hash_raddr), .rdata(hash_rdata)
    );

    for (genvar g = 0; g < 3; g++) begin : g_slice
        lzwe_ram #(.WIDTH(CAM_ENTRIES), .DEPTH(SLICE_DEPTH)) u_bm_ram (
            .aclk(aclk), .we(bm_we), .waddr(bm_waddr[g]), .wdata(bm_wdata[g]),
            .raddr(bm_raddr[g]), .rdata(bm_rdata[g])
        );
    end

    lzwe_ram #(.WIDTH(CODE_W), .DEPTH(CAM_ENTRIES)) u_cam_val_ram (
        .aclk(aclk), .we(cv_we), .waddr(fill_reg[IDX_W-1:0]),
        .wdata(free_code_reg[CODE_W-1:0]), .raddr(cv_raddr), .rdata(cv_rdata)
    );

    // Lookup decode from the held key and hash
    always_comb begin
        h_fin      = h_reg ^ (h_reg >> 16);
        hash_raddr = h_fin[HB_W-1:0];
        bm_raddr[0] = {6'd0, key_reg[20:18]};
        bm_raddr[1] = key_reg[17:9];
        bm_raddr[2] = key_reg[8:0];
        way0 = hash_rdata[WAY_W-1:0];
        way1 = hash_rdata[2*WAY_W-1:WAY_W];
        way0_hit = way0[WAY_W-1] && (way0[KEY_W-1:0] == key_reg);
        way1_hit = way1[WAY_W-1] && (way1[KEY_W-1:0] == key_reg);
        match = bm_rdata[0] & bm_rdata[1] & bm_rdata[2];
        match_idx = '0;
        for (int i = CAM_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_idx = IDX_W'(i);
            end
        end
        cv_raddr  = match_idx;
        new_entry = {1'b1, free_code_reg[CODE_W-1:0], key_reg};
        new_bit   = CAM_ENTRIES'(1) << fill_reg;
        out_free  = !m_valid_reg || m_tready;
        count_inc = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        mix_a = h_reg ^ s_reg;
        mix_a = mix_a ^ (mix_a >> 16);
        mix_b = h_reg ^ (h_reg >> 13);
    end

    // Next state, datapath updates and memory writes
    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        h_next         = h_reg;
        s_next         = s_reg;
        prefix_next    = prefix_reg;
        free_code_next = free_code_reg;
        count_next     = count_reg;
        fail_next      = fail_reg;
        fill_next      = fill_reg;
        clr_next       = clr_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_code_next    = m_code_reg;
        m_count_next   = m_count_reg;
        m_fail_next    = m_fail_reg;
        m_last_next    = m_last_reg;
        s_tready       = 1'b0;
        hash_we        = 1'b0;
        hash_waddr     = hash_raddr;
        hash_wdata     = hash_rdata;
        bm_we          = 1'b0;
        cv_we          = 1'b0;
        for (int g = 0; g < 3; g++) begin
            bm_waddr[g] = bm_raddr[g];
            bm_wdata[g] = bm_rdata[g] | new_bit;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    last_next = s_tlast;
                    if (s_tuser) begin
                        prefix_next    = {5'd0, s_tdata};
                        count_next     = '0;
                        fail_next      = 1'b0;
                        clr_next       = '0;
                        free_code_next = FIRST_CODE;
                        fill_next      = '0;
                        state_next     = ST_CLEAR;
                    end else begin
                        key_next   = {prefix_reg, s_tdata};
                        state_next = ST_H1;
                    end
                end
            end
            ST_CLEAR: begin
                // Sweep zeros through the hash and bitmap memories
                hash_we    = 1'b1;
                hash_waddr = clr_reg[HB_W-1:0];
                hash_wdata = '0;
                bm_we      = 1'b1;
                for (int g = 0; g < 3; g++) begin
                    bm_waddr[g] = clr_reg[SLICE_W-1:0];
                    bm_wdata[g] = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_H1: begin
                h_next     = ~{11'd0, key_reg} * MUR_C1;
                state_next = ST_H2;
            end
            ST_H2: begin
                s_next     = rotl15(h_reg) * MUR_C2;
                state_next = ST_H3;
            end
            ST_H3: begin
                h_next     = rotl13(HASH_SEED ^ s_reg) * MUR_MUL5 + MUR_ADD;
                state_next = ST_H4;
            end
            ST_H4: begin
                h_next     = mix_a * MUR_F1;
                state_next = ST_H5;
            end
            ST_H5: begin
                h_next     = mix_b * MUR_F2;
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // Ways first, then fall back to the CAM bitmaps
                if (way0_hit) begin
                    prefix_next = way0[WAY_W-2:KEY_W];
                    state_next  = last_reg ? ST_FLUSH : ST_IDLE;
                end else if (way1_hit) begin
                    prefix_next = way1[WAY_W-2:KEY_W];
                    state_next  = last_reg ? ST_FLUSH : ST_IDLE;
                end else if (|match) begin
                    state_next = ST_CAMV;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_CAMV: begin
                prefix_next = cv_rdata;
                state_next  = last_reg ? ST_FLUSH : ST_IDLE;
            end
            ST_EMIT: begin
                // Emit the prefix and insert the new key while codes and a free way or CAM entry remain
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = prefix_reg;
                    m_count_next = '0;
                    m_fail_next  = 1'b0;
                    m_last_next  = 1'b0;
                    count_next   = count_inc;
                    prefix_next  = {5'd0, key_reg[7:0]};
                    if (free_code_reg >= CODE_LIMIT) begin
                        free_code_next = CODE_LIMIT;
                        fail_next      = 1'b1;
                    end else begin
                        free_code_next = free_code_reg + 1'b1;
                        if (!way0[WAY_W-1]) begin
                            hash_we    = 1'b1;
                            hash_wdata = {way1, new_entry};
                        end else if (!way1[WAY_W-1]) begin
                            hash_we    = 1'b1;
                            hash_wdata = {new_entry, way0};
                        end else if (fill_reg < CAM_FULL) begin
                            bm_we     = 1'b1;
                            cv_we     = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end else begin
                            fail_next = 1'b1;
                        end
                    end
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                // Flush the final prefix with the chunk totals
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = prefix_reg;
                    m_count_next = count_inc;
                    m_fail_next  = fail_reg;
                    m_last_next  = 1'b1;
                    count_next   = '0;
                    fail_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            prefix_reg    <= '0;
            free_code_reg <= FIRST_CODE;
            count_reg     <= '0;
            fail_reg      <= 1'b0;
            fill_reg      <= '0;
            clr_reg       <= '0;
            last_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            free_code_reg <= free_code_next;
            count_reg     <= count_next;
            fail_reg      <= fail_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            last_reg      <= last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        h_reg       <= h_next;
        s_reg       <= s_next;
        m_code_reg  <= m_code_next;
        m_count_reg <= m_count_next;
        m_fail_reg  <= m_fail_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_fail_reg, m_count_reg, m_code_reg};

    // Code allocation never passes the 13-bit limit
    a_code_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        free_code_reg <= CODE_LIMIT)
        else $error("next free code beyond limit");

    // CAM fill never passes its size
    a_cam_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAM_FULL)
        else $error("CAM overfilled");

    // Totals only ride on the chunk-end beat
    a_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_count_reg == '0 && !m_fail_reg))
        else $error("totals on a non-final beat");

    // No byte is taken while a clearing pass runs
    a_clear_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input ready during clear");
endmodule
`default_nettype wire

// ===== verif/tb_lzw_encoder_hash_cam_dict.sv =====
// Self-checking testbench for the LZW encoder with hashed two-way dictionary and CAM overflow.
`default_nettype none

typedef struct {
    bit [12:0] code;
    bit        chunk_end;
    bit [13:0] count;
    bit        failed;
} lzw_code_beat_t;

// Scoreboard: own LZW dictionary predictor plus a queue of expected code beats.
class lzw_scoreboard;
    bit             way_valid [32768];
    bit [20:0]      way_key   [32768];
    bit [12:0]      way_code  [32768];
    bit [63:0]      slice_map [3][512];
    bit [12:0]      cam_code  [64];
    int             cam_used;
    bit [12:0]      prefix;
    int             free_code;
    int             emitted;
    bit             failed;
    lzw_code_beat_t pending [$];
    int             errors;
    int             beats_checked;
    int             failed_chunks;
    int             chunk_ends;

    function new();
        clear_dict();
        prefix  = 0;
        emitted = 0;
        failed  = 0;
        errors  = 0;
    endfunction

    function void clear_dict();
        foreach (way_valid[i]) way_valid[i] = 0;
        foreach (slice_map[s, j]) slice_map[s][j] = '0;
        cam_used  = 0;
        free_code = 256;
    endfunction

    function bit [31:0] scramble(bit [31:0] k);
        k = k * lzwe_pkg::MUR_C1;
        k = {k[16:0], k[31:17]};
        return k * lzwe_pkg::MUR_C2;
    endfunction

    function bit [13:0] bucket(bit [20:0] key);
        bit [31:0] k;
        bit [31:0] h;
        k = ~{11'd0, key};
        h = lzwe_pkg::HASH_SEED;
        h ^= scramble(k);
        h = {h[18:0], h[31:19]};
        h = h * 32'd5 + lzwe_pkg::MUR_ADD;
        h ^= scramble(k);
        h ^= h >> 16;
        h = h * lzwe_pkg::MUR_F1;
        h ^= h >> 13;
        h = h * lzwe_pkg::MUR_F2;
        h ^= h >> 16;
        return h[13:0];
    endfunction

    // Search both ways, then the CAM with lowest matching entry first.
    function bit find_code(bit [20:0] key, output bit [12:0] code);
        bit [13:0] b;
        bit [63:0] hits;
        b = bucket(key);
        code = 0;
        for (int w = 0; w < 2; w++)
            if (way_valid[b*2+w] && way_key[b*2+w] == key) begin
                code = way_code[b*2+w];
                return 1;
            end
        hits = slice_map[0][{6'd0, key[20:18]}] & slice_map[1][key[17:9]]
             & slice_map[2][key[8:0]];
        for (int i = 0; i < 64; i++)
            if (hits[i]) begin
                code = cam_code[i];
                return 1;
            end
        return 0;
    endfunction

    function bit add_code(bit [20:0] key, bit [12:0] code);
        bit [13:0] b;
        b = bucket(key);
        for (int w = 0; w < 2; w++)
            if (!way_valid[b*2+w]) begin
                way_valid[b*2+w] = 1;
                way_key[b*2+w]   = key;
                way_code[b*2+w]  = code;
                return 1;
            end
        if (cam_used >= 64) return 0;
        slice_map[0][{6'd0, key[20:18]}][cam_used] = 1;
        slice_map[1][key[17:9]][cam_used] = 1;
        slice_map[2][key[8:0]][cam_used]  = 1;
        cam_code[cam_used] = code;
        cam_used++;
        return 1;
    endfunction

    // Predict the code beats caused by one accepted byte.
    function void note_byte(bit [7:0] data, bit first, bit last);
        lzw_code_beat_t e;
        bit [20:0] key;
        bit [12:0] code;
        if (first) begin
            clear_dict();
            emitted = 0;
            failed  = 0;
            prefix  = {5'd0, data};
        end else begin
            key = {prefix, data};
            if (find_code(key, code)) begin
                prefix = code;
            end else begin
                e = '{prefix, 0, 0, 0};
                pending.push_back(e);
                if (emitted < 8192) emitted++;
                if (free_code >= 8192) begin
                    free_code = 8192;
                    failed = 1;
                end else begin
                    if (!add_code(key, free_code[12:0])) failed = 1;
                    free_code++;
                end
                prefix = {5'd0, data};
            end
        end
        if (last) begin
            if (emitted < 8192) emitted++;
            e = '{prefix, 1, emitted[13:0], failed};
            pending.push_back(e);
            chunk_ends++;
            if (failed) failed_chunks++;
            emitted = 0;
            failed  = 0;
        end
    endfunction

    function void check_beat(bit [12:0] code, bit chunk_end, bit [13:0] count, bit fl);
        lzw_code_beat_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected beat code=%0d chunk_end=%0b", $time, code, chunk_end);
            errors++;
            return;
        end
        e = pending.pop_front();
        beats_checked++;
        if (e.code != code) begin
            $display("%0t: out_code expected %0d actual %0d", $time, e.code, code);
            errors++;
        end
        if (e.chunk_end != chunk_end) begin
            $display("%0t: chunk_end expected %0b actual %0b", $time, e.chunk_end, chunk_end);
            errors++;
        end
        if (e.count != count) begin
            $display("%0t: code_count expected %0d actual %0d", $time, e.count, count);
            errors++;
        end
        if (e.failed != fl) begin
            $display("%0t: dict_failure expected %0b actual %0b", $time, e.failed, fl);
            errors++;
        end
    endfunction
endclass

module tb_lzw_encoder_hash_cam_dict;
    localparam int CYCLE_LIMIT = 6000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    lzw_scoreboard sb;
    int  cycles;
    bit  no_idle;
    int  hold_req;
    bit  hold_done;
    int  bytes_sent;

    lzw_encoder_hash_cam_dict dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial aclk = 0;
    always #5 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (no_idle) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata[12:0], m_tlast, m_tdata[26:13], m_tdata[27]);
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input bit [7:0] data, input bit first, input bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= data;
        s_tuser  <= first;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(data, first, last);
        bytes_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // One chunk; small alphabets make dictionary hits and long prefixes
    task automatic send_chunk(input int len, input int alpha, input bit with_start);
        bit [7:0] base;
        base = 8'($urandom);
        for (int i = 0; i < len; i++)
            send_byte(alpha >= 256 ? 8'($urandom) : 8'(base + $urandom_range(0, alpha - 1)),
                      with_start && i == 0, i == len - 1);
    endtask

    initial begin
        int len;
        sb = new();
        cycles = 0;
        no_idle = 0;
        hold_req = 0;
        hold_done = 0;
        bytes_sent = 0;
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = 0;
        s_tuser  = 0;
        s_tlast  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Bytes with no chunk start right after reset: empty dictionary, prefix zero
        send_byte(8'h00, 0, 0);
        send_byte(8'hFF, 0, 0);
        send_byte(8'h00, 0, 1);
        // First and last on the same byte
        send_byte(8'hAB, 1, 1);
        // Repeats build prefixes, then both byte extremes
        send_byte(8'h00, 1, 0);
        send_byte(8'h00, 0, 0);
        send_byte(8'h00, 0, 0);
        send_byte(8'h00, 0, 0);
        send_byte(8'h00, 0, 0);
        send_byte(8'hFF, 0, 0);
        send_byte(8'hFF, 0, 0);
        send_byte(8'hFF, 0, 0);
        send_byte(8'h55, 0, 1);
        // Dictionary and prefix kept past a chunk end
        send_byte(8'h00, 0, 0);
        send_byte(8'h00, 0, 1);
        // Two-byte chunk
        send_byte(8'h7F, 1, 0);
        send_byte(8'h80, 0, 1);
        drain();

        // Random chunks, mostly well formed
        while (bytes_sent < 1150) begin
            no_idle = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 60);
            case ($urandom_range(0, 9))
                0:       send_chunk(len, 256, 1);
                1:       send_chunk(len, 4, 0);
                2: begin
                    // Short chunk followed at once by another
                    send_chunk($urandom_range(2, 10), 3, 1);
                    s_tvalid <= 0;
                    send_chunk(len, 3, 1);
                end
                default: send_chunk(len, $urandom_range(1, 8), 1);
            endcase
            if (bytes_sent > 600 && !hold_done) begin
                // Long receiver hold while the sender keeps offering misses
                hold_done = 1;
                hold_req = 400;
                send_chunk(80, 256, 0);
            end
            if (bytes_sent > 1000 && bytes_sent < 1100) drain();
        end

        // Long random chunk, mostly misses, then a short repetitive one
        no_idle = 1;
        send_chunk(400, 256, 1);
        no_idle = 0;
        send_chunk(20, 2, 1);

        drain();
        repeat (40) @(posedge aclk);
        $display("run covered %0d bytes, %0d chunk ends (%0d with dictionary failure),",
                 bytes_sent, sb.chunk_ends, sb.failed_chunks);
        $display("%0d code beats checked, %0d mismatches", sb.beats_checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/lzwe_pkg.sv
design/lzwe_ram.sv
design/lzw_encoder_hash_cam_dict.sv
verif/tb_lzw_encoder_hash_cam_dict.sv
